>>> rtl/usc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usc_pkg
// Shared types, codes and scale tables of the unit scale converter.
// ----------------------------------------------------------------------------
package usc_pkg;

  typedef struct packed {
    logic [2:0]        value_kind;
    logic [63:0]       raw_value;
    logic signed [3:0] in_dim_space;
    logic signed [3:0] in_dim_time;
    logic signed [3:0] in_dim_count;
    logic [3:0]        in_scale_space;
    logic [3:0]        in_scale_time;
    logic signed [3:0] in_scale_count;
  } in_item_t;

  typedef struct packed {
    logic [63:0] scaled_value;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic signed [3:0] dim_space;
    logic signed [3:0] dim_time;
    logic signed [3:0] dim_count;
    logic [3:0]        scale_space;
    logic [3:0]        scale_time;
    logic signed [3:0] scale_count;
  } cfg_regs_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CONV    = 2'd1;
  localparam logic [1:0] ST_UNIT    = 2'd2;
  localparam logic [1:0] ST_DIVZERO = 2'd3;

  localparam logic [2:0] CFG_DIM_SPACE   = 3'd0;
  localparam logic [2:0] CFG_DIM_TIME    = 3'd1;
  localparam logic [2:0] CFG_DIM_COUNT   = 3'd2;
  localparam logic [2:0] CFG_SCALE_SPACE = 3'd3;
  localparam logic [2:0] CFG_SCALE_TIME  = 3'd4;
  localparam logic [2:0] CFG_SCALE_COUNT = 3'd5;

  localparam logic [2:0] KIND_I32 = 3'd0;
  localparam logic [2:0] KIND_U32 = 3'd1;
  localparam logic [2:0] KIND_I64 = 3'd2;
  localparam logic [2:0] KIND_U64 = 3'd3;

  // Datapath commands.
  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD, OP_MUL_MULT, OP_MUL_DIV, OP_CANCEL_START, OP_CANCEL_DONE,
    OP_FINAL_START, OP_FINAL_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [63:0] factor;
  } dp_cmd_t;

  typedef struct packed {
    logic        div_busy;
    logic        div_zero;
    logic [63:0] div_q;
  } dp_stat_t;

  function automatic logic [63:0] space_lo(input logic [3:0] c);
    case (c)
      4'd0:    space_lo = 64'd1 << 20;
      4'd1:    space_lo = 64'd1 << 10;
      default: space_lo = 64'd1;
    endcase
  endfunction

  function automatic logic [63:0] space_hi(input logic [3:0] c);
    case (c)
      4'd3:    space_hi = 64'd1 << 10;
      4'd4:    space_hi = 64'd1 << 20;
      4'd5:    space_hi = 64'd1 << 30;
      4'd6:    space_hi = 64'd1 << 40;
      default: space_hi = 64'd1;
    endcase
  endfunction

  function automatic logic [63:0] time_lo(input logic [3:0] c);
    case (c)
      4'd0:    time_lo = 64'd1000000000;
      4'd1:    time_lo = 64'd1000000;
      4'd2:    time_lo = 64'd1000;
      default: time_lo = 64'd1;
    endcase
  endfunction

  function automatic logic [63:0] time_hi(input logic [3:0] c);
    case (c)
      4'd4:    time_hi = 64'd60;
      4'd5:    time_hi = 64'd3600;
      default: time_hi = 64'd1;
    endcase
  endfunction

  function automatic logic [63:0] pow10(input logic [3:0] n);
    case (n)
      4'd0:    pow10 = 64'd1;
      4'd1:    pow10 = 64'd10;
      4'd2:    pow10 = 64'd100;
      4'd3:    pow10 = 64'd1000;
      4'd4:    pow10 = 64'd10000;
      4'd5:    pow10 = 64'd100000;
      4'd6:    pow10 = 64'd1000000;
      4'd7:    pow10 = 64'd10000000;
      4'd8:    pow10 = 64'd100000000;
      4'd9:    pow10 = 64'd1000000000;
      4'd10:   pow10 = 64'd10000000000;
      4'd11:   pow10 = 64'd100000000000;
      4'd12:   pow10 = 64'd1000000000000;
      4'd13:   pow10 = 64'd10000000000000;
      4'd14:   pow10 = 64'd100000000000000;
      default: pow10 = 64'd1000000000000000;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> rtl/usc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usc_datapath
// Holds mult and div; multiplies by 16-bit chunks of the factor and
// runs a shared radix-2 signed/unsigned 64-bit divider.
// ----------------------------------------------------------------------------
module usc_datapath import usc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire dp_cmd_t    cmd,
  input  wire logic [2:0] kind,
  output dp_stat_t        stat,
  output logic            mul_busy
);

  logic [63:0] mult_r, mult_nxt, div_r, div_nxt;
  logic        uns_r, uns_nxt;
  // Chunked multiplier.
  logic [63:0] macc_r, macc_nxt, mop_r, mop_nxt, mfac_r, mfac_nxt;
  logic [1:0]  mcnt_r, mcnt_nxt;
  logic        mbusy_r, mbusy_nxt, mtgt_r, mtgt_nxt;
  // Divider.
  logic [63:0] rem_r, rem_nxt, quo_r, quo_nxt, dsr_r, dsr_nxt;
  logic [6:0]  dcnt_r, dcnt_nxt;
  logic        dbusy_r, dbusy_nxt, qneg_r, qneg_nxt;
  logic [64:0] trial, shrem;
  logic [63:0] a_op, b_op, a_mag, b_mag;
  logic        a_neg, b_neg;
  logic [63:0] part;

  assign part = mop_r * {48'd0, mfac_r[15:0]};

  always_comb begin
    a_op = 64'd0;
    b_op = 64'd1;
    case (cmd.op)
      OP_CANCEL_START: begin a_op = mult_r; b_op = div_r; end
      OP_FINAL_START:  begin
        // mult already holds the value times the ratio.
        a_op = mult_r;
        a_op = a_op + (($signed(div_r) < 0 ? 64'd0 - ((64'd0 - div_r) >> 1) : div_r >> 1));
        b_op = div_r;
      end
      default: ;
    endcase
    a_neg = a_op[63] && !(uns_r && cmd.op == OP_FINAL_START);
    b_neg = b_op[63] && !(uns_r && cmd.op == OP_FINAL_START);
    a_mag = a_neg ? 64'd0 - a_op : a_op;
    b_mag = b_neg ? 64'd0 - b_op : b_op;
    shrem = {rem_r, quo_r[63]};
    trial = shrem - {1'b0, dsr_r};
  end

  always_comb begin
    mult_nxt = mult_r; div_nxt = div_r; uns_nxt = uns_r;
    macc_nxt = macc_r; mop_nxt = mop_r; mfac_nxt = mfac_r; mcnt_nxt = mcnt_r;
    mbusy_nxt = mbusy_r; mtgt_nxt = mtgt_r;
    rem_nxt = rem_r; quo_nxt = quo_r; dsr_nxt = dsr_r; dcnt_nxt = dcnt_r;
    dbusy_nxt = dbusy_r; qneg_nxt = qneg_r;
    if (mbusy_r) begin
      macc_nxt = macc_r + part;
      mop_nxt  = mop_r << 16;
      mfac_nxt = mfac_r >> 16;
      mcnt_nxt = mcnt_r + 2'd1;
      if (mcnt_r == 2'd3) begin
        mbusy_nxt = 1'b0;
        if (mtgt_r) div_nxt = macc_r + part;
        else        mult_nxt = macc_r + part;
      end
    end
    if (dbusy_r) begin
      dcnt_nxt = dcnt_r - 7'd1;
      quo_nxt  = {quo_r[62:0], !trial[64]};
      rem_nxt  = trial[64] ? shrem[63:0] : trial[63:0];
      if (dcnt_r == 7'd1) dbusy_nxt = 1'b0;
    end
    case (cmd.op)
      OP_LOAD: begin
        mult_nxt = 64'd1;
        div_nxt  = 64'd1;
        uns_nxt  = kind == KIND_U64 || kind == KIND_U32;
        // uint32 divides as signed 64-bit; its zero-extended value stays positive.
        if (kind == KIND_U32) uns_nxt = 1'b0;
      end
      OP_MUL_MULT, OP_MUL_DIV: begin
        mtgt_nxt  = cmd.op == OP_MUL_DIV;
        mop_nxt   = cmd.op == OP_MUL_DIV ? div_r : mult_r;
        mfac_nxt  = cmd.factor;
        macc_nxt  = 64'd0;
        mcnt_nxt  = 2'd0;
        mbusy_nxt = 1'b1;
      end
      OP_CANCEL_START, OP_FINAL_START: begin
        rem_nxt   = 64'd0;
        quo_nxt   = a_mag;
        dsr_nxt   = b_mag;
        qneg_nxt  = a_neg != b_neg;
        dcnt_nxt  = 7'd64;
        dbusy_nxt = 1'b1;
      end
      OP_CANCEL_DONE: begin
        if (rem_r == 64'd0) begin
          mult_nxt = qneg_r ? 64'd0 - quo_r : quo_r;
          div_nxt  = 64'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      dbusy_r <= 1'b0;
    end else begin
      mbusy_r <= mbusy_nxt;
      dbusy_r <= dbusy_nxt;
    end
    mult_r <= mult_nxt; div_r <= div_nxt; uns_r <= uns_nxt;
    macc_r <= macc_nxt; mop_r <= mop_nxt; mfac_r <= mfac_nxt; mcnt_r <= mcnt_nxt;
    mtgt_r <= mtgt_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt; dsr_r <= dsr_nxt;
    dcnt_r <= dcnt_nxt; qneg_r <= qneg_nxt;
  end

  assign stat.div_busy = dbusy_r;
  assign stat.div_zero = div_r == 64'd0;
  assign stat.div_q    = qneg_r ? 64'd0 - quo_r : quo_r;
  assign mul_busy = mbusy_r;

endmodule
`default_nettype wire

>>> rtl/usc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usc_ctrl
// Sequencer: checks units, issues the mult and div power multiplies of
// each step, then the cancel division, the multiply by the value and the
// final division, and emits the result item.
// ----------------------------------------------------------------------------
module usc_ctrl import usc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire in_item_t  item,
  input  wire cfg_regs_t cfg,
  input  wire dp_stat_t  stat,
  input  wire logic      mul_busy,
  output logic           busy,
  output dp_cmd_t        cmd,
  output logic           out_valid,
  output out_item_t      out_item
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_PREP, S_MUL, S_MWAIT, S_ZCHK, S_CANCEL, S_CWAIT,
    S_CDONE, S_NMUL, S_NWAIT, S_FINAL, S_FWAIT
  } state_t;

  state_t      state_r;
  in_item_t    it_r;
  logic [1:0]  ph_r;          // 0 space, 1 time, 2 count
  logic [3:0]  cnt_r;         // remaining multiply steps
  logic        side_r;        // 0 mult, 1 div
  logic [63:0] dfac_r, mfac_r;
  logic        pos_r;
  logic [1:0]  stat_r;

  logic signed [4:0] isc, osc;
  logic signed [3:0] dimv;
  logic [3:0]  dmag;
  logic        need_c;

  assign isc = 5'(it_r.in_scale_count);
  assign osc = 5'(cfg.scale_count);
  assign need_c = it_r.in_dim_count != 0 || (it_r.in_dim_space == 0 && it_r.in_dim_time == 0);

  always_comb begin
    case (ph_r)
      2'd0:    dimv = it_r.in_dim_space;
      2'd1:    dimv = it_r.in_dim_time;
      default: dimv = it_r.in_dim_count;
    endcase
    dmag = dimv[3] ? 4'(-dimv) : 4'(dimv);
  end

  always_comb begin
    cmd.op = OP_NONE;
    cmd.factor = 64'd1;
    if (state_r == S_IDLE && start) cmd.op = OP_LOAD;
    if (state_r == S_MUL) begin
      cmd.op = side_r ? OP_MUL_DIV : OP_MUL_MULT;
      cmd.factor = (side_r ^ !pos_r) ? dfac_r : mfac_r;
    end
    if (state_r == S_NMUL) begin
      cmd.op = OP_MUL_MULT;
      case (it_r.value_kind)
        KIND_I32: cmd.factor = {{32{it_r.raw_value[31]}}, it_r.raw_value[31:0]};
        KIND_U32: cmd.factor = {32'd0, it_r.raw_value[31:0]};
        default:  cmd.factor = it_r.raw_value;
      endcase
    end
    if (state_r == S_CANCEL) cmd.op = OP_CANCEL_START;
    if (state_r == S_CDONE)  cmd.op = OP_CANCEL_DONE;
    if (state_r == S_FINAL)  cmd.op = OP_FINAL_START;
  end

  assign busy = state_r != S_IDLE;

  // Power-of-ten factors for the count ratio; each exponent is at most 15.
  logic [63:0] dten, mten;
  logic signed [5:0] dexp, mexp;
  always_comb begin
    dexp = (isc < 0 ? 6'(-isc) : 6'd0) + (osc > 0 ? 6'(osc) : 6'd0);
    mexp = (isc > 0 ? 6'(isc) : 6'd0) + (osc < 0 ? 6'(-osc) : 6'd0);
    dten = pow10(dexp[3:0]);
    mten = pow10(mexp[3:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= state_r == S_FWAIT && !stat.div_busy;
      unique case (state_r)
        S_IDLE: if (start) begin
          it_r <= item;
          ph_r <= 2'd0;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          stat_r <= ST_OK;
          if (it_r.in_dim_space != cfg.dim_space || it_r.in_dim_time != cfg.dim_time
              || it_r.in_dim_count != cfg.dim_count) begin
            stat_r <= ST_CONV; state_r <= S_FWAIT;
          end else if (it_r.in_dim_space != 0 &&
                       (it_r.in_scale_space > 4'd6 || cfg.scale_space > 4'd6)) begin
            stat_r <= ST_UNIT; state_r <= S_FWAIT;
          end else if (it_r.in_dim_time != 0 &&
                       (it_r.in_scale_time > 4'd5 || cfg.scale_time > 4'd5)) begin
            stat_r <= ST_UNIT; state_r <= S_FWAIT;
          end else state_r <= S_PREP;
        end
        S_PREP: begin
          pos_r  <= !dimv[3];
          cnt_r  <= dmag;
          side_r <= 1'b0;
          case (ph_r)
            2'd0: begin
              dfac_r <= space_lo(it_r.in_scale_space) * space_hi(cfg.scale_space);
              mfac_r <= space_hi(it_r.in_scale_space) * space_lo(cfg.scale_space);
            end
            2'd1: begin
              dfac_r <= time_lo(it_r.in_scale_time) * time_hi(cfg.scale_time);
              mfac_r <= time_hi(it_r.in_scale_time) * time_lo(cfg.scale_time);
            end
            default: begin
              dfac_r <= dten;
              mfac_r <= mten;
            end
          endcase
          if (ph_r == 2'd2 && !need_c) state_r <= S_ZCHK;
          else if (ph_r == 2'd2 && dimv == 0) begin
            // Bare count ratio: mult := m, div := d via multiply from one.
            pos_r <= 1'b1; cnt_r <= 4'd1; state_r <= S_MUL;
          end else if (dimv == 0) ph_r <= ph_r + 2'd1;
          else state_r <= S_MUL;
        end
        S_MUL: state_r <= S_MWAIT;
        S_MWAIT: if (!mul_busy) begin
          if (!side_r) begin
            side_r <= 1'b1; state_r <= S_MUL;
          end else begin
            side_r <= 1'b0;
            if (cnt_r == 4'd1) begin
              if (ph_r == 2'd2) state_r <= S_ZCHK;
              else begin ph_r <= ph_r + 2'd1; state_r <= S_PREP; end
            end else begin
              cnt_r <= cnt_r - 4'd1; state_r <= S_MUL;
            end
          end
        end
        S_ZCHK: begin
          if (stat.div_zero) begin stat_r <= ST_DIVZERO; state_r <= S_FWAIT; end
          else state_r <= S_CANCEL;
        end
        S_CANCEL: state_r <= S_CWAIT;
        S_CWAIT: if (!stat.div_busy) state_r <= S_CDONE;
        S_CDONE: begin
          if (it_r.value_kind > KIND_U64) begin stat_r <= ST_CONV; state_r <= S_FWAIT; end
          else state_r <= S_NMUL;
        end
        S_NMUL: state_r <= S_NWAIT;
        S_NWAIT: if (!mul_busy) state_r <= S_FINAL;
        S_FINAL: state_r <= S_FWAIT;
        S_FWAIT: if (!stat.div_busy) begin
          out_item.status <= stat_r;
          if (stat_r != ST_OK) out_item.scaled_value <= 64'd0;
          else if (it_r.value_kind == KIND_I32 || it_r.value_kind == KIND_U32)
            out_item.scaled_value <= {32'd0, stat.div_q[31:0]};
          else out_item.scaled_value <= stat.div_q;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/unit_scale_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unit_scale_converter
// Rescales an integer metric value to the configured target units.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// its result is out. The result is on out_data for one cycle with out_valid;
// the receiver cannot stall it.
// Each power step issues two chunked multiplies, one step per unit of each
// nonzero dimension (at most 8 per dimension), or a single step for a bare
// count ratio. Then come the cancel division, the multiply by the value and
// the final division. A dimension or scale code error skips all of these; a
// zero divisor ends before the cancel division and an unsupported kind after
// it. busy falls in the out_valid cycle, so the next item can be taken at the
// edge that ends it.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// keep such writes between items, as the block does not enforce it; writes to
// an index beyond the list are ignored. Reset drops any item in work and
// restores the target units (dims 0, time scale seconds).
// ----------------------------------------------------------------------------
module unit_scale_converter import usc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [3:0] cfg_wdata
);

  cfg_regs_t cfg_r;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  logic      mul_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{dim_space: 4'sd0, dim_time: 4'sd0, dim_count: 4'sd0,
                 scale_space: 4'd0, scale_time: 4'd3, scale_count: 4'sd0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIM_SPACE:   cfg_r.dim_space   <= cfg_wdata;
        CFG_DIM_TIME:    cfg_r.dim_time    <= cfg_wdata;
        CFG_DIM_COUNT:   cfg_r.dim_count   <= cfg_wdata;
        CFG_SCALE_SPACE: cfg_r.scale_space <= cfg_wdata;
        CFG_SCALE_TIME:  cfg_r.scale_time  <= cfg_wdata;
        CFG_SCALE_COUNT: cfg_r.scale_count <= cfg_wdata;
        default: ;
      endcase
    end
  end

  usc_datapath u_dp (
    .clk, .rst_n, .cmd, .kind(in_data.value_kind), .stat, .mul_busy
  );

  usc_ctrl u_ctrl (
    .clk, .rst_n, .start, .item(in_data), .cfg(cfg_r), .stat, .mul_busy,
    .busy, .cmd, .out_valid, .out_item(out_data)
  );

endmodule
`default_nettype wire

>>> rtl/usc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usc_checker
// Port-level checks of the unit scale converter.
// ----------------------------------------------------------------------------
module usc_checker import usc_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_item_t out_data
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("item not taken");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.scaled_value == 64'd0)
    else $error("error result carries a value");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy with result out");

endmodule

bind unit_scale_converter usc_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .out_data
);
`default_nettype wire

>>> bench/unit_scale_converter_test.sv
// ----------------------------------------------------------------------------
// unit_scale_converter_test
// Self-checking bench for the unit scale converter. Items are sent through
// the start/busy handshake, every result is compared with an in-bench
// conversion model, and the target units are changed between phases.
// ----------------------------------------------------------------------------
module unit_scale_converter_test;
  import usc_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [3:0]  cfg_wdata;

  cfg_regs_t   target_units;
  out_item_t   pending_results[$];
  int          mismatches;
  int          items_sent;
  int          results_seen;
  int          cycles;
  bit          gaps_on;

  unit_scale_converter dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] magnitude(logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  function automatic logic [63:0] signed_quotient(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    q = magnitude(a) / magnitude(b);
    return (a[63] != b[63]) ? 64'd0 - q : q;
  endfunction

  function automatic void raise_ratio(int dim, logic [63:0] d, logic [63:0] m,
                                      inout logic [63:0] dv, inout logic [63:0] ml);
    for (int k = 0; k < dim; k++) begin
      dv = dv * d;
      ml = ml * m;
    end
    for (int k = dim; k < 0; k++) begin
      ml = ml * d;
      dv = dv * m;
    end
  endfunction

  function automatic logic [63:0] space_low(logic [3:0] c);
    case (c)
      4'd0:    return 64'd1 << 20;
      4'd1:    return 64'd1 << 10;
      default: return 64'd1;
    endcase
  endfunction

  function automatic logic [63:0] space_high(logic [3:0] c);
    case (c)
      4'd3:    return 64'd1 << 10;
      4'd4:    return 64'd1 << 20;
      4'd5:    return 64'd1 << 30;
      4'd6:    return 64'd1 << 40;
      default: return 64'd1;
    endcase
  endfunction

  function automatic logic [63:0] time_low(logic [3:0] c);
    case (c)
      4'd0:    return 64'd1000000000;
      4'd1:    return 64'd1000000;
      4'd2:    return 64'd1000;
      default: return 64'd1;
    endcase
  endfunction

  function automatic logic [63:0] time_high(logic [3:0] c);
    case (c)
      4'd4:    return 64'd60;
      4'd5:    return 64'd3600;
      default: return 64'd1;
    endcase
  endfunction

  function automatic out_item_t convert_value(in_item_t it, cfg_regs_t u);
    out_item_t   r;
    int          ds, dt, dc, isc, osc;
    logic [63:0] dv, ml, d, m, half, num;
    ds = it.in_dim_space;
    dt = it.in_dim_time;
    dc = it.in_dim_count;
    isc = it.in_scale_count;
    osc = u.scale_count;
    dv = 64'd1;
    ml = 64'd1;
    r = '0;
    if (it.in_dim_space != u.dim_space || it.in_dim_time != u.dim_time ||
        it.in_dim_count != u.dim_count) begin
      r.status = ST_CONV;
      return r;
    end
    if (ds != 0) begin
      if (it.in_scale_space > 6 || u.scale_space > 6) begin
        r.status = ST_UNIT;
        return r;
      end
      raise_ratio(ds, space_low(it.in_scale_space) * space_high(u.scale_space),
                  space_high(it.in_scale_space) * space_low(u.scale_space), dv, ml);
    end
    if (dt != 0) begin
      if (it.in_scale_time > 5 || u.scale_time > 5) begin
        r.status = ST_UNIT;
        return r;
      end
      raise_ratio(dt, time_low(it.in_scale_time) * time_high(u.scale_time),
                  time_high(it.in_scale_time) * time_low(u.scale_time), dv, ml);
    end
    if (dc != 0 || (ds == 0 && dt == 0)) begin
      d = 64'd1;
      m = 64'd1;
      for (int k = isc; k < 0; k++) d = d * 10;
      for (int k = 0; k < isc; k++) m = m * 10;
      for (int k = osc; k < 0; k++) m = m * 10;
      for (int k = 0; k < osc; k++) d = d * 10;
      if (dc != 0) raise_ratio(dc, d, m, dv, ml);
      else begin
        ml = m;
        dv = d;
      end
    end
    if (dv == 0) begin
      r.status = ST_DIVZERO;
      return r;
    end
    if (magnitude(ml) % magnitude(dv) == 0) begin
      ml = signed_quotient(ml, dv);
      dv = 64'd1;
    end
    half = signed_quotient(dv, 64'd2);
    case (it.value_kind)
      KIND_I32: begin
        num = {{32{it.raw_value[31]}}, it.raw_value[31:0]};
        r.scaled_value = signed_quotient(num * ml + half, dv) & 64'hFFFF_FFFF;
      end
      KIND_U32: begin
        num = {32'd0, it.raw_value[31:0]};
        r.scaled_value = signed_quotient(num * ml + half, dv) & 64'hFFFF_FFFF;
      end
      KIND_I64: r.scaled_value = signed_quotient(it.raw_value * ml + half, dv);
      KIND_U64: r.scaled_value = (it.raw_value * ml + half) / dv;
      default:  r.status = ST_CONV;
    endcase
    return r;
  endfunction

  // Results cannot be held off, so every strobe is checked at the edge ending it.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: value %h status %0d",
               out_data.scaled_value, out_data.status);
        mismatches++;
      end else begin
        if (out_data.scaled_value !== pending_results[0].scaled_value) begin
          $error("scaled_value expected %h actual %h",
                 pending_results[0].scaled_value, out_data.scaled_value);
          mismatches++;
        end
        if (out_data.status !== pending_results[0].status) begin
          $error("status expected %0d actual %0d",
                 pending_results[0].status, out_data.status);
          mismatches++;
        end
        void'(pending_results.pop_front());
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge that accepts the item with start
  // still high unless gaps_on adds a random pause, so a following item can go out without a gap.
  task automatic send_item(in_item_t it);
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(convert_value(it, target_units));
    items_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_units(cfg_regs_t u);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_DIM_SPACE;   cfg_wdata <= u.dim_space;   @(posedge clk);
    cfg_index <= CFG_DIM_TIME;    cfg_wdata <= u.dim_time;    @(posedge clk);
    cfg_index <= CFG_DIM_COUNT;   cfg_wdata <= u.dim_count;   @(posedge clk);
    cfg_index <= CFG_SCALE_SPACE; cfg_wdata <= u.scale_space; @(posedge clk);
    cfg_index <= CFG_SCALE_TIME;  cfg_wdata <= u.scale_time;  @(posedge clk);
    cfg_index <= CFG_SCALE_COUNT; cfg_wdata <= u.scale_count; @(posedge clk);
    // Indexes past the list must be ignored.
    cfg_index <= 3'd7;            cfg_wdata <= 4'hF;          @(posedge clk);
    cfg_we <= 1'b0;
    target_units = u;
    @(posedge clk);
  endtask

  function automatic in_item_t matching_item(logic [2:0] kind, logic [63:0] raw);
    in_item_t it;
    it.value_kind = kind;
    it.raw_value = raw;
    it.in_dim_space = target_units.dim_space;
    it.in_dim_time = target_units.dim_time;
    it.in_dim_count = target_units.dim_count;
    it.in_scale_space = 4'($urandom_range(0, 6));
    it.in_scale_time = 4'($urandom_range(0, 5));
    it.in_scale_count = 4'($urandom);
    return it;
  endfunction

  function automatic logic [63:0] random_raw();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h0000_0000_8000_0000;
      4: return 64'($urandom_range(0, 5000));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic cfg_regs_t random_units();
    cfg_regs_t u;
    u.dim_space = 4'($urandom_range(0, 4)) - 4'd2;
    u.dim_time = 4'($urandom_range(0, 4)) - 4'd2;
    u.dim_count = 4'($urandom_range(0, 2)) - 4'd1;
    u.scale_space = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 6));
    u.scale_time = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 5));
    u.scale_count = 4'($urandom_range(0, 6)) - 4'd3;
    return u;
  endfunction

  task automatic test_reset_defaults();
    in_item_t it;
    it = matching_item(KIND_I64, 64'd12345);
    it.in_scale_count = -4'sd3;
    send_item(it);
    it = matching_item(KIND_U64, '1);
    send_item(it);
  endtask

  task automatic test_kinds_and_extremes();
    in_item_t it;
    for (int k = 0; k < 8; k++) begin
      it = matching_item(3'(k), (k % 2) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h8000_0000_8000_0000);
      it.in_scale_count = (k < 4) ? 4'sd7 : -4'sd8;
      send_item(it);
    end
    it = matching_item(KIND_I32, 64'h0000_0000_7FFF_FFFF);
    send_item(it);
  endtask

  task automatic test_error_cases();
    cfg_regs_t u;
    in_item_t  it;
    u = '{dim_space: 4'sd2, dim_time: -4'sd1, dim_count: 4'sd1,
          scale_space: 4'd6, scale_time: 4'd5, scale_count: -4'sd8};
    write_units(u);
    it = matching_item(KIND_I64, 64'd1000);
    it.in_dim_time = 4'sd1;            // dimension mismatch
    send_item(it);
    it = matching_item(KIND_I64, 64'd1000);
    it.in_scale_space = 4'd7;          // bad space code
    send_item(it);
    it = matching_item(KIND_I64, 64'd1000);
    it.in_scale_time = 4'd15;          // bad time code
    send_item(it);
    it = matching_item(KIND_U64, 64'd1000);
    it.in_scale_space = 4'd0;          // byte to Ebyte squared wraps the divisor to zero
    send_item(it);
    it = matching_item(3'd6, 64'd1000);
    send_item(it);
    u = '{dim_space: 4'sd0, dim_time: 4'sd0, dim_count: -4'sd8,
          scale_space: 4'd15, scale_time: 4'd15, scale_count: 4'sd7};
    write_units(u);
    // Scale codes of zero dimensions are not checked.
    it = matching_item(KIND_I32, 64'hFFFF_FFFF);
    it.in_scale_space = 4'd15;
    it.in_scale_time = 4'd12;
    send_item(it);
    it = matching_item(KIND_I64, 64'h8000_0000_0000_0000);
    send_item(it);
  endtask

  task automatic test_random_phases();
    cfg_regs_t u;
    in_item_t  it;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 2)
        u = '{dim_space: 4'sd7, dim_time: -4'sd8, dim_count: 4'sd7,
              scale_space: 4'd0, scale_time: 4'd0, scale_count: -4'sd8};
      else if (phase == 5)
        u = '{dim_space: -4'sd8, dim_time: 4'sd7, dim_count: -4'sd8,
              scale_space: 4'd6, scale_time: 4'd5, scale_count: 4'sd7};
      else u = random_units();
      write_units(u);
      gaps_on = (phase != 7);
      for (int n = 0; n < 170; n++) begin
        it = matching_item(($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 3)),
                           random_raw());
        case ($urandom_range(0, 19))
          0: it.in_dim_space = 4'($urandom);
          1: it.in_dim_count = 4'($urandom);
          2: it.in_scale_space = 4'($urandom);
          3: it.in_scale_time = 4'($urandom);
          default: ;
        endcase
        send_item(it);
        // Let everything drain once mid-phase so the block sees an empty pipe.
        if (n == 85 && phase == 3) drain_results();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_DIM_SPACE;
    cfg_wdata = '0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    cycles = 0;
    gaps_on = 1'b1;
    target_units = '{dim_space: 4'sd0, dim_time: 4'sd0, dim_count: 4'sd0,
                     scale_space: 4'd0, scale_time: 4'd3, scale_count: 4'sd0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_kinds_and_extremes();
    test_error_cases();
    test_random_phases();
    drain_results();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end
    $display("Sent %0d items over 11 target unit settings, %0d results checked.",
             items_sent, results_seen);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
rtl/usc_pkg.sv
rtl/usc_datapath.sv
rtl/usc_ctrl.sv
rtl/unit_scale_converter.sv
rtl/usc_checker.sv
bench/unit_scale_converter_test.sv
